FILE: src/uule_pkg.sv
// Shared types, constants and the character mapping of the uuencode line encoder.
`default_nettype none

package uule_pkg;

    localparam int CNT_W  = 6;   // byte count of one line
    localparam int CHAR_W = 7;   // ASCII character

    localparam logic [CHAR_W-1:0] CHAR_BIAS = 7'd32;
    localparam logic [CHAR_W-1:0] BACKQUOTE = 7'd96;
    localparam logic [CHAR_W-1:0] NEWLINE   = 7'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_C0,
        ST_C1,
        ST_C2,
        ST_C3,
        ST_NL
    } uule_state_t;

    // six bits plus bias; zero goes out as backquote when enabled
    function automatic logic [CHAR_W-1:0] map_char(input logic [5:0] six,
                                                  input logic       zbq);
        logic [CHAR_W-1:0] c;
        c = {1'b0, six} + CHAR_BIAS;
        if (six == 6'd0 && zbq) begin
            c = BACKQUOTE;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: src/uuencode_line_encoder.sv
// Top level of the uuencode line encoder: line store sequencing and output register.
//
// Raw bytes arrive one per transfer on the s_ side and are written into a line
// store RAM, one byte per cycle while the block is idle. When the line holds
// LINE_BYTES bytes, or the byte comes with s_tlast set, the block stops taking
// input and sends the line on the m_ side: a length character (count + 32),
// four characters per group of three bytes (6 bits + 32 each, a short last
// group padded with zeros), and a newline (10) flagged with m_tlast. The burst
// rate of one character per cycle while m_tready is high is kept with the
// single read port of the line store: three reads for each group of four
// characters, with each read issued one slot ahead of the character that
// needs it. Reads and writes never overlap, since the store is only written
// while idle. The cfg_* channel sets zero_as_backquote (reset 1): when 1, any
// character of value 32 goes out as a backquote. Write it only between lines.
`default_nettype none

module uuencode_line_encoder #(
    parameter int LINE_BYTES = 45
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // input stream
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,   // final_byte
    // encoded character stream
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,   // [6:0] out_char, [7] zero
    output logic            m_tlast,   // end_of_line
    // mode register write
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data   // zero_as_backquote
);

    import uule_pkg::*;

    localparam int ADDR_W = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int IDX_W  = CNT_W + 1;   // room for index + 3 past the count

    // state
    uule_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [1:0]         b0_lo_reg, b0_lo_next;
    logic [3:0]         b1_lo_reg, b1_lo_next;
    logic [5:0]         b2_lo_reg, b2_lo_next;
    logic               zbq_reg;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]  m_char_reg, m_char_next;
    logic               m_last_reg, m_last_next;

    // RAM side
    logic               rd_req;
    logic [IDX_W-1:0]   rd_idx;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [7:0]         rd_data;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;

    logic               in_xfer;
    logic               out_free;
    logic [CNT_W-1:0]   cnt_inc;
    logic [IDX_W-1:0]   cnt_ext;
    logic [IDX_W-1:0]   idx_p1, idx_p2, idx_p3;
    logic [7:0]         byte_cur;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {1'b0, m_char_reg};
    assign m_tlast   = m_last_reg;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign cnt_ext  = {1'b0, cnt_reg};
    assign idx_p1   = idx_reg + IDX_W'(1);
    assign idx_p2   = idx_reg + IDX_W'(2);
    assign idx_p3   = idx_reg + IDX_W'(3);

    assign wr_en   = in_xfer;
    assign wr_addr = cnt_reg[ADDR_W-1:0];

    // no read past the bytes held; a skipped read reads as a zero pad byte
    assign rd_en   = rd_req && (rd_idx < cnt_ext);
    assign rd_addr = rd_idx[ADDR_W-1:0];

    uule_line_ram #(
        .DEPTH  (LINE_BYTES),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (s_tdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // byte for the slot of the current state, zero past the count
    always_comb begin
        byte_cur = 8'd0;
        case (state_reg)
            ST_C0:   if (idx_reg < cnt_ext) byte_cur = rd_data;
            ST_C1:   if (idx_p1 < cnt_ext) byte_cur = rd_data;
            ST_C2:   if (idx_p2 < cnt_ext) byte_cur = rd_data;
            default: byte_cur = 8'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            zbq_reg     <= 1'b1;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                zbq_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        b0_lo_reg  <= b0_lo_next;
        b1_lo_reg  <= b1_lo_next;
        b2_lo_reg  <= b2_lo_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        b0_lo_next   = b0_lo_reg;
        b1_lo_next   = b1_lo_reg;
        b2_lo_next   = b2_lo_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        rd_req       = 1'b0;
        rd_idx       = idx_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    cnt_next = cnt_inc;
                    if (cnt_inc == CNT_W'(LINE_BYTES) || s_tlast) begin
                        state_next = ST_LEN;
                    end
                end
            end
            ST_LEN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = map_char(cnt_reg, zbq_reg);
                    m_last_next  = 1'b0;
                    idx_next     = '0;
                    rd_req       = 1'b1;
                    rd_idx       = '0;
                    state_next   = ST_C0;
                end
            end
            ST_C0: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = map_char(byte_cur[7:2], zbq_reg);
                    m_last_next  = 1'b0;
                    b0_lo_next   = byte_cur[1:0];
                    rd_req       = 1'b1;
                    rd_idx       = idx_p1;
                    state_next   = ST_C1;
                end
            end
            ST_C1: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = map_char({b0_lo_reg, byte_cur[7:4]}, zbq_reg);
                    m_last_next  = 1'b0;
                    b1_lo_next   = byte_cur[3:0];
                    rd_req       = 1'b1;
                    rd_idx       = idx_p2;
                    state_next   = ST_C2;
                end
            end
            ST_C2: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = map_char({b1_lo_reg, byte_cur[7:6]}, zbq_reg);
                    m_last_next  = 1'b0;
                    b2_lo_next   = byte_cur[5:0];
                    state_next   = ST_C3;
                end
            end
            ST_C3: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = map_char(b2_lo_reg, zbq_reg);
                    m_last_next  = 1'b0;
                    idx_next     = idx_p3;
                    if (idx_p3 < cnt_ext) begin
                        rd_req     = 1'b1;
                        rd_idx     = idx_p3;
                        state_next = ST_C0;
                    end else begin
                        state_next = ST_NL;
                    end
                end
            end
            ST_NL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = NEWLINE;
                    m_last_next  = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a full line always flushes, so an idle count stays below the line size
    a_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> cnt_reg < CNT_W'(LINE_BYTES))
        else $error("line count reached line size while idle");

    // the newline transfer empties the line and returns to idle
    a_nl_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_NL && out_free) |=> (cnt_reg == '0 && state_reg == ST_IDLE))
        else $error("newline did not clear the line");

    // only the newline carries the end-of-line flag
    a_eol_char: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> m_char_reg == NEWLINE)
        else $error("end of line on a character other than newline");

    // store reads stay within the written part of the line
    a_rd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (rd_idx < cnt_ext && state_reg != ST_IDLE))
        else $error("line store read outside the held bytes");

endmodule

`default_nettype wire

FILE: src/uule_line_ram.sv
// Line store: one write port, one read port, registered read data.
`default_nettype none

module uule_line_ram #(
    parameter int DEPTH  = 45,
    parameter int ADDR_W = 6
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [7:0]        wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [7:0]        rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
